// File: design/tftp_server_transfer_control_top_assert.svh
// Assertion macros for the TFTP transfer control top level.
// Expects clk and rst in the scope of use; no other dependencies.
`ifndef TFTP_SERVER_TRANSFER_CONTROL_TOP_ASSERT_SVH
`define TFTP_SERVER_TRANSFER_CONTROL_TOP_ASSERT_SVH

// condition implies check in the same cycle
`define TSTC_ASSERT_NOW(label, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error("tftp transfer control: same-cycle check failed");

// condition implies check in the following cycle
`define TSTC_ASSERT_NEXT(label, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error("tftp transfer control: next-cycle check failed");

`endif

// File: design/tftp_stc_pkg.sv
// Shared types and codes for the TFTP server transfer control block.
// No dependencies.
`default_nettype none
package tftp_stc_pkg;

  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ERR_ACCESS  = 2'd0;
  localparam logic [1:0] ERR_ILLEGAL = 2'd1;
  localparam logic [1:0] ERR_UNK_TID = 2'd2;

  localparam logic [1:0] REG_FILE_LENGTH  = 2'd0;
  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_RETRIES  = 2'd2;

  localparam logic [15:0] HDR_BYTES = 16'd4;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_READ  = 3'b010,
    MODE_WRITE = 3'b100
  } mode_t;

  typedef struct packed {
    logic [15:0] file_length;
    logic [15:0] block_length;
    logic [7:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] opcode;
    logic [15:0] block_number;
    logic [15:0] packet_length;
    logic [31:0] source_address;
    logic [15:0] source_port;
  } req_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
    logic [15:0] block_out;
    logic [1:0]  error_kind;
    logic [16:0] data_offset;
    logic [15:0] data_length;
  } res_t;

endpackage
`default_nettype wire

// File: design/tftp_stc_regs.sv
// APB configuration registers: file length, block length, retry limit.
// Depends on tftp_stc_pkg.
`default_nettype none
module tftp_stc_regs import tftp_stc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.file_length  <= 16'd2048;
      cfg.block_length <= 16'd512;
      cfg.max_retries  <= 8'd5;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_FILE_LENGTH:  cfg.file_length  <= pwdata[15:0];
        REG_BLOCK_LENGTH: cfg.block_length <= pwdata[15:0];
        REG_MAX_RETRIES:  cfg.max_retries  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FILE_LENGTH:  prdata = {16'd0, cfg.file_length};
      REG_BLOCK_LENGTH: prdata = {16'd0, cfg.block_length};
      REG_MAX_RETRIES:  prdata = {24'd0, cfg.max_retries};
      default:          prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: design/tftp_stc_core.sv
// Input register, transfer state and per-event decision logic.
// Depends on tftp_stc_pkg.
`default_nettype none
module tftp_stc_core import tftp_stc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic in_valid,
  output logic      in_ready,
  input  req_t      in_req,
  input  wire logic load_ok,
  output logic      stage_valid,
  output logic      adv,
  output logic      res_valid,
  output res_t      res
);

  req_t        req;
  mode_t       mode, mode_next;
  logic [15:0] cur_blk, cur_blk_next;
  logic [17:0] bytes_rem, bytes_rem_next;
  logic [16:0] file_off, file_off_next;
  logic [7:0]  retry, retry_next;
  logic [31:0] cl_addr, cl_addr_next;
  logic [15:0] cl_port, cl_port_next;

  logic        same_addr, same_port;
  logic        do_data, do_ack, do_err;
  logic [1:0]  ek;
  logic [15:0] dlen;

  assign adv      = stage_valid && load_ok;
  assign in_ready = !stage_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      cur_blk   <= 16'd0;
      bytes_rem <= 18'd0;
      file_off  <= 17'd0;
      retry     <= 8'd0;
      cl_addr   <= 32'd0;
      cl_port   <= 16'd0;
    end else if (adv) begin
      mode      <= mode_next;
      cur_blk   <= cur_blk_next;
      bytes_rem <= bytes_rem_next;
      file_off  <= file_off_next;
      retry     <= retry_next;
      cl_addr   <= cl_addr_next;
      cl_port   <= cl_port_next;
    end
  end

  assign same_addr = req.source_address == cl_addr;
  assign same_port = req.source_port == cl_port;

  always_comb begin
    mode_next      = mode;
    cur_blk_next   = cur_blk;
    bytes_rem_next = bytes_rem;
    file_off_next  = file_off;
    retry_next     = retry;
    cl_addr_next   = cl_addr;
    cl_port_next   = cl_port;
    do_data        = 1'b0;
    do_ack         = 1'b0;
    do_err         = 1'b0;
    ek             = ERR_ACCESS;
    if (req.req_type) begin
      if (mode != MODE_IDLE) begin
        if (retry >= cfg.max_retries) begin
          retry_next = 8'd0;
          mode_next  = MODE_IDLE;
        end else begin
          retry_next = retry + 8'd1;
          do_data    = mode == MODE_READ;
          do_ack     = mode != MODE_READ;
        end
      end
    end else begin
      retry_next = 8'd0;
      case (req.opcode) inside
        OP_RRQ, OP_WRQ: begin
          if (mode != MODE_IDLE) begin
            do_err = 1'b1;
            ek     = ERR_ACCESS;
          end else begin
            cl_addr_next = req.source_address;
            cl_port_next = req.source_port;
            if (req.opcode == OP_RRQ) begin
              cur_blk_next   = 16'd1;
              file_off_next  = 17'd0;
              bytes_rem_next = {2'd0, cfg.file_length};
              mode_next      = MODE_READ;
              do_data        = 1'b1;
            end else begin
              cur_blk_next = 16'd0;
              mode_next    = MODE_WRITE;
              do_ack       = 1'b1;
            end
          end
        end
        OP_DATA: begin
          if (!same_addr || !same_port || mode != MODE_WRITE) begin
            do_err = 1'b1;
            ek     = ERR_ILLEGAL;
          end else if (req.block_number == cur_blk) begin
            do_ack = 1'b1;
          end else if (req.block_number == cur_blk + 16'd1) begin
            cur_blk_next = req.block_number;
            if ({1'b0, req.packet_length} < {1'b0, cfg.block_length} + {1'b0, HDR_BYTES}) begin
              mode_next = MODE_IDLE;
            end
            do_ack = 1'b1;
          end else begin
            mode_next = MODE_IDLE;
            do_err    = 1'b1;
            ek        = ERR_UNK_TID;
          end
        end
        OP_ACK: begin
          if (!same_addr || !same_port || mode != MODE_READ) begin
            do_err = 1'b1;
            ek     = ERR_ILLEGAL;
          end else if (req.block_number == cur_blk - 16'd1) begin
            do_data = 1'b1;
          end else if (req.block_number == cur_blk) begin
            if (bytes_rem < {2'd0, cfg.block_length}) begin
              mode_next = MODE_IDLE;
            end else begin
              bytes_rem_next = bytes_rem - {2'd0, cfg.block_length};
              cur_blk_next   = cur_blk + 16'd1;
              file_off_next  = file_off + {1'b0, cfg.block_length};
              do_data        = 1'b1;
            end
          end else begin
            mode_next = MODE_IDLE;
            do_err    = 1'b1;
            ek        = ERR_UNK_TID;
          end
        end
        OP_ERROR: begin
          if (same_addr && same_port) begin
            mode_next = MODE_IDLE;
          end
        end
        default: begin
          if (same_addr || same_port) begin
            mode_next = MODE_IDLE;
            do_err    = 1'b1;
            ek        = ERR_ILLEGAL;
          end
        end
      endcase
    end
  end

  // data and ack commands always describe the updated state
  assign dlen = (bytes_rem_next < {2'd0, cfg.block_length}) ? bytes_rem_next[15:0]
                                                            : cfg.block_length;

  assign res_valid = do_data || do_ack || do_err;

  always_comb begin
    res = '0;
    if (do_err) begin
      res.send_kind    = KIND_ERR;
      res.dest_address = req.source_address;
      res.dest_port    = req.source_port;
      res.error_kind   = ek;
    end else begin
      res.send_kind    = do_data ? KIND_DATA : KIND_ACK;
      res.dest_address = cl_addr_next;
      res.dest_port    = cl_port_next;
      res.block_out    = cur_blk_next;
      if (do_data) begin
        res.data_offset = file_off_next;
        res.data_length = dlen;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/tftp_stc_out.sv
// Result register for send commands, decoupling the stall from the input side.
// Depends on tftp_stc_pkg.
`default_nettype none
module tftp_stc_out import tftp_stc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic res_valid,
  input  res_t      res,
  output logic      load_ok,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  assign load_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

// File: design/tftp_server_transfer_control_top.sv
// Single-client TFTP server transfer control, top level.
// Depends on tftp_stc_pkg, tftp_stc_regs, tftp_stc_core, tftp_stc_out and the assert header.
//
// Usage:
//   Slave stream s_*: one event per transfer, either a received packet header
//   (s_tuser = 0) or a receive timeout tick (s_tuser = 1).
//   Master stream m_*: at most one send command per event (data block, ack
//   or error), m_tuser giving the kind.
//   APB port: file length, block length and retry limit; write only while idle.
// Timing:
//   An event waits in the input register, where the next transfer state
//   and the command are decided; both are registered as the event leaves
//   it, the command into the result register that drives m_*.
//   One event per cycle is sustained while m_tready stays high; the state
//   update in the core is the only loop.
// Reset: rst (synchronous) empties both registers, returns the transfer to
//   idle and loads the register defaults 2048, 512 and 5.
// Stall: while m_tready is low the pending command holds, the event in the
//   input register waits, and s_tready drops once that register is full.
`default_nettype none
`include "tftp_server_transfer_control_top_assert.svh"
module tftp_server_transfer_control_top import tftp_stc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // opcode[15:0], block_number[31:16], packet_length[47:32],
  // source_address[79:48], source_port[95:80]
  input  wire logic [95:0]  s_tdata,
  // req_type[0]
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // dest_address[31:0], dest_port[47:32], block_out[63:48], error_kind[65:64],
  // data_offset[82:66], data_length[98:83], zero[103:99]
  output logic      [103:0] m_tdata,
  // send_kind[1:0]
  output logic      [1:0]   m_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  cfg_t cfg;
  req_t in_req;
  res_t res, out_res;
  logic load_ok, stage_valid, adv, res_valid;

  assign in_req.req_type       = s_tuser;
  assign in_req.opcode         = s_tdata[15:0];
  assign in_req.block_number   = s_tdata[31:16];
  assign in_req.packet_length  = s_tdata[47:32];
  assign in_req.source_address = s_tdata[79:48];
  assign in_req.source_port    = s_tdata[95:80];

  tftp_stc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tftp_stc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_req      (in_req),
    .load_ok     (load_ok),
    .stage_valid (stage_valid),
    .adv         (adv),
    .res_valid   (res_valid),
    .res         (res)
  );

  tftp_stc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .res_valid (res_valid),
    .res       (res),
    .load_ok   (load_ok),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tuser = out_res.send_kind;
  assign m_tdata = {5'd0, out_res.data_length, out_res.data_offset, out_res.error_kind,
                    out_res.block_out, out_res.dest_port, out_res.dest_address};

  `TSTC_ASSERT_NEXT(a_stage_holds, stage_valid && !load_ok, stage_valid)
  `TSTC_ASSERT_NOW(a_ack_no_payload, m_tvalid && m_tuser == KIND_ACK,
                   m_tdata[98:66] == 33'd0 && m_tdata[65:64] == ERR_ACCESS)
  `TSTC_ASSERT_NOW(a_err_no_block, m_tvalid && m_tuser == KIND_ERR,
                   m_tdata[63:48] == 16'd0 && m_tdata[98:66] == 33'd0)

endmodule
`default_nettype wire
